[sv/bdpb_pkg.sv]
// Package for the brush dab pixel blend core: constants, codes and payload types.
// Used by bdpb_div and brush_dab_pixel_blend_core; depends on nothing.
`default_nettype none

package bdpb_pkg;

  localparam int FB = 15;
  localparam int ONE = 1 << FB;
  localparam logic [15:0] ONE_W = 16'(ONE);

  // signed working widths of the colour path
  localparam int X_W = 20;
  localparam int DX_W = 24;

  // divider geometry
  localparam int DIV_NUM_W = 42;
  localparam int DIV_DEN_W = 20;

  // Q16 luma weights, element 0 = red
  localparam logic [2:0][15:0] LUMA_W = {16'd4732, 16'd46871, 16'd13933};

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LOCK   = 2'd1,
    MODE_POSTER = 2'd2,
    MODE_COLOUR = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_RED     = 3'd1,
    REG_GREEN   = 3'd2,
    REG_BLUE    = 3'd3,
    REG_ALPHA   = 3'd4,
    REG_OPACITY = 3'd5,
    REG_LEVELS  = 3'd6
  } reg_e;

  typedef struct packed {
    logic [15:0] coverage;
    logic [15:0] bottom_red;
    logic [15:0] bottom_green;
    logic [15:0] bottom_blue;
    logic [15:0] bottom_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
  } pix_out_t;

  // per-pixel data that travels down the pipeline
  typedef struct packed {
    mode_e                 mode;
    logic [15:0]           opa;
    logic [15:0]           inv;
    logic [15:0]           t;
    logic [15:0]           ba;
    logic [2:0][15:0]      c;
    logic                  zero_ba;
    logic [2:0]            big;
    logic [2:0][16:0]      p;
    logic [2:0][X_W-1:0]   x;
    logic [X_W-1:0]        l;
    logic [X_W-1:0]        lo;
    logic [X_W-1:0]        hi;
    logic [X_W-1:0]        oml;
    logic [X_W-1:0]        den1;
    logic [X_W-1:0]        den2;
    logic                  en1;
    logic                  en2;
    logic [2:0]            neg;
    logic [2:0][DX_W-1:0]  dx;
    logic [2:0][15:0]      sx;
  } side_t;

endpackage

`default_nettype wire

[sv/brush_dab_pixel_blend_core.sv]
// Brush dab pixel blend core: fully pipelined, one pixel accepted every clock.
// busy_o stays low.
// The pipeline is three 42-stage restoring dividers in series (de-premultiply or
// posterize, then the two colour clips) plus 15 arithmetic stages.
// Reset clears all valid bits and loads the register defaults; the receiver cannot stall.
// Depends on bdpb_pkg and bdpb_div.
`default_nettype none

module brush_dab_pixel_blend_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bdpb_pkg::pix_in_t   in_data_i,
  output logic                busy_o,
  output logic                done_o,
  output bdpb_pkg::pix_out_t  result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int FB   = bdpb_pkg::FB;
  localparam int XW   = bdpb_pkg::X_W;
  localparam int DXW  = bdpb_pkg::DX_W;
  localparam int NW   = bdpb_pkg::DIV_NUM_W;
  localparam int DW   = bdpb_pkg::DIV_DEN_W;
  localparam logic [15:0] ONE_W = bdpb_pkg::ONE_W;

  function automatic logic [XW-1:0] luma_trunc(input logic signed [XW+18:0] v);
    logic signed [XW+18:0] a;
    a = (v < 0) ? v + $signed((XW+19)'(65535)) : v;
    return XW'(a >>> 16);
  endfunction

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------- configuration registers ----------------
  bdpb_pkg::mode_e  mode_q;
  logic [2:0][15:0] brush_q;
  logic [15:0]      balpha_q, opacity_q;
  logic [7:0]       levels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= bdpb_pkg::MODE_NORMAL;
      brush_q   <= '0;
      balpha_q  <= ONE_W;
      opacity_q <= ONE_W;
      levels_q  <= 8'd8;
    end else if (cfg_valid_i) begin
      unique case (bdpb_pkg::reg_e'(cfg_index_i))
        bdpb_pkg::REG_MODE:    mode_q     <= bdpb_pkg::mode_e'(cfg_data_i[1:0]);
        bdpb_pkg::REG_RED:     brush_q[0] <= cfg_data_i;
        bdpb_pkg::REG_GREEN:   brush_q[1] <= cfg_data_i;
        bdpb_pkg::REG_BLUE:    brush_q[2] <= cfg_data_i;
        bdpb_pkg::REG_ALPHA:   balpha_q   <= cfg_data_i;
        bdpb_pkg::REG_OPACITY: opacity_q  <= cfg_data_i;
        bdpb_pkg::REG_LEVELS:  levels_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [7:0] n_eff;
  assign n_eff = (levels_q == 8'd0) ? 8'd1 : levels_q;

  // brush luma, recomputed every cycle from static registers
  logic [2:0][31:0] blp_q;
  logic [15:0]      bl_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) blp_q[i] <= brush_q[i] * bdpb_pkg::LUMA_W[i];
    bl_q <= 16'((34'(blp_q[0]) + 34'(blp_q[1]) + 34'(blp_q[2])) >> 16);
  end

  // ---------------- valid bits ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic v11_q, v12_q, v13_q, v14_q, v15_q, done_q;
  logic va, vb, vc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0;
      v11_q <= 1'b0; v12_q <= 1'b0; v13_q <= 1'b0; v14_q <= 1'b0;
      v15_q <= 1'b0; done_q <= 1'b0;
    end else begin
      v1_q   <= start_i && !busy_o;
      v2_q   <= v1_q;
      v3_q   <= va;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      v8_q   <= v7_q;
      v9_q   <= v8_q;
      v11_q  <= vb;
      v12_q  <= v11_q;
      v13_q  <= vc;
      v14_q  <= v13_q;
      v15_q  <= v14_q;
      done_q <= v15_q;
    end
  end

  // ---------------- S1: capture, coverage and posterize products ----------------
  bdpb_pkg::pix_in_t px1_q;
  logic [31:0]       oraw1_q;
  logic [2:0][23:0]  cq1_q;

  always_ff @(posedge clk_i) begin
    px1_q   <= in_data_i;
    oraw1_q <= in_data_i.coverage * opacity_q;
    cq1_q[0] <= in_data_i.bottom_red   * n_eff;
    cq1_q[1] <= in_data_i.bottom_green * n_eff;
    cq1_q[2] <= in_data_i.bottom_blue  * n_eff;
  end

  // ---------------- S2: opacity, top alpha, first divider operands ----------------
  logic [16:0]          opa_raw;
  logic [15:0]          opa_s, inv_s, ca_s;
  logic [31:0]          tprod;
  logic [2:0][15:0]     c_s;
  logic [2:0][9:0]      q_s;
  bdpb_pkg::side_t      side2_d, side2_q;
  logic [2:0][NW-1:0]   num2_d, num2_q;
  logic [DW-1:0]        den2_d, den2_q;

  always_comb begin
    c_s     = {px1_q.bottom_blue, px1_q.bottom_green, px1_q.bottom_red};
    opa_raw = 17'(oraw1_q >> FB);
    opa_s   = (opa_raw > 17'(bdpb_pkg::ONE)) ? ONE_W : opa_raw[15:0];
    inv_s   = ONE_W - opa_s;
    if (mode_q == bdpb_pkg::MODE_NORMAL) begin
      ca_s = (balpha_q > ONE_W) ? ONE_W : balpha_q;
    end else begin
      ca_s = (px1_q.bottom_alpha > ONE_W) ? ONE_W : px1_q.bottom_alpha;
    end
    tprod = opa_s * ca_s;

    side2_d         = '0;
    side2_d.mode    = mode_q;
    side2_d.opa     = opa_s;
    side2_d.inv     = inv_s;
    side2_d.t       = 16'(tprod >> FB);
    side2_d.ba      = px1_q.bottom_alpha;
    side2_d.c       = c_s;
    side2_d.zero_ba = (px1_q.bottom_alpha == 16'd0);

    for (int i = 0; i < 3; i++) begin
      q_s[i] = 10'((25'(cq1_q[i]) + 25'(bdpb_pkg::ONE / 2)) >> FB);
      side2_d.big[i] = {2'b00, c_s[i]} >= {px1_q.bottom_alpha, 2'b00};
      if (mode_q == bdpb_pkg::MODE_POSTER) begin
        num2_d[i] = NW'(q_s[i]) << FB;
      end else begin
        num2_d[i] = NW'(c_s[i]) << FB;
      end
    end

    if (mode_q == bdpb_pkg::MODE_POSTER) begin
      den2_d = DW'(n_eff);
    end else if (px1_q.bottom_alpha == 16'd0) begin
      den2_d = DW'(1);
    end else begin
      den2_d = DW'(px1_q.bottom_alpha);
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q <= side2_d;
    num2_q  <= num2_d;
    den2_q  <= den2_d;
  end

  // ---------------- divider A: posterize level or straight colour ----------------
  logic [2:0][NW-1:0] quo_a;
  bdpb_pkg::side_t    side_a;

  bdpb_div u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .num_i   (num2_q),
    .den_i   (den2_q),
    .side_i  (side2_q),
    .valid_o (va),
    .quo_o   (quo_a),
    .side_o  (side_a)
  );

  // ---------------- S3: posterized value or clamped straight colour ----------------
  bdpb_pkg::side_t side3_d, side3_q;

  always_comb begin
    side3_d = side_a;
    for (int i = 0; i < 3; i++) begin
      if (side_a.mode == bdpb_pkg::MODE_POSTER) begin
        side3_d.p[i] = quo_a[i][16:0];
      end else if (side_a.zero_ba) begin
        side3_d.p[i] = '0;
      end else if (side_a.big[i] || (quo_a[i] > NW'(bdpb_pkg::ONE))) begin
        side3_d.p[i] = 17'(bdpb_pkg::ONE);
      end else begin
        side3_d.p[i] = quo_a[i][16:0];
      end
    end
  end

  always_ff @(posedge clk_i) side3_q <= side3_d;

  // ---------------- S4: luma products of the straight colour ----------------
  bdpb_pkg::side_t  side4_q;
  logic [2:0][31:0] sprod_q;

  always_ff @(posedge clk_i) begin
    side4_q <= side3_q;
    for (int i = 0; i < 3; i++) sprod_q[i] <= side3_q.p[i][15:0] * bdpb_pkg::LUMA_W[i];
  end

  // ---------------- S5: luma shift onto the brush colour ----------------
  bdpb_pkg::side_t    side5_d, side5_q;
  logic [15:0]        ls;
  logic signed [XW-1:0] d_s;

  always_comb begin
    side5_d = side4_q;
    ls  = 16'((34'(sprod_q[0]) + 34'(sprod_q[1]) + 34'(sprod_q[2])) >> 16);
    d_s = $signed(XW'(ls)) - $signed(XW'(bl_q));
    for (int i = 0; i < 3; i++) side5_d.x[i] = XW'($signed(XW'(brush_q[i])) + d_s);
  end

  always_ff @(posedge clk_i) side5_q <= side5_d;

  // ---------------- S6: luma products of the shifted colour ----------------
  bdpb_pkg::side_t              side6_q;
  logic signed [XW+16:0]        xprod_q [3];

  always_ff @(posedge clk_i) begin
    side6_q <= side5_q;
    for (int i = 0; i < 3; i++) begin
      xprod_q[i] <= $signed(side5_q.x[i]) * $signed({1'b0, bdpb_pkg::LUMA_W[i]});
    end
  end

  // ---------------- S7: luma, min and max ----------------
  bdpb_pkg::side_t       side7_d, side7_q;
  logic signed [XW+18:0] lsum;
  logic signed [XW-1:0]  x0, x1, x2, mn, mx;

  always_comb begin
    side7_d = side6_q;
    lsum = (XW+19)'(xprod_q[0]) + (XW+19)'(xprod_q[1]) + (XW+19)'(xprod_q[2]);
    x0 = $signed(side6_q.x[0]);
    x1 = $signed(side6_q.x[1]);
    x2 = $signed(side6_q.x[2]);
    mn = (x0 < x1) ? x0 : x1;
    mn = (mn < x2) ? mn : x2;
    mx = (x0 > x1) ? x0 : x1;
    mx = (mx > x2) ? mx : x2;
    side7_d.l  = luma_trunc(lsum);
    side7_d.lo = mn;
    side7_d.hi = mx;
  end

  always_ff @(posedge clk_i) side7_q <= side7_d;

  // ---------------- S8: clip conditions and divisors ----------------
  bdpb_pkg::side_t      side8_d, side8_q;
  logic signed [XW-1:0] l8, lo8, hi8, dn1, dn2;

  always_comb begin
    side8_d = side7_q;
    l8  = $signed(side7_q.l);
    lo8 = $signed(side7_q.lo);
    hi8 = $signed(side7_q.hi);
    dn1 = l8 - lo8;
    dn2 = hi8 - l8;
    side8_d.den1 = dn1;
    side8_d.den2 = dn2;
    side8_d.en1  = (lo8 < 0) && (dn1 > 0);
    side8_d.en2  = (hi8 > bdpb_pkg::ONE) && (dn2 > 0);
    side8_d.oml  = XW'($signed(XW'(bdpb_pkg::ONE)) - l8);
    for (int i = 0; i < 3; i++) begin
      side8_d.dx[i] = DXW'($signed(side7_q.x[i]) - l8);
    end
  end

  always_ff @(posedge clk_i) side8_q <= side8_d;

  // ---------------- S9: low clip numerators ----------------
  bdpb_pkg::side_t         side9_q, sideb_in;
  logic signed [2*XW-1:0]  pr1_q [3];
  logic [2:0][NW-1:0]      numb;
  logic [DW-1:0]           denb;
  logic [2*XW-1:0]         mag1;

  always_ff @(posedge clk_i) begin
    side9_q <= side8_q;
    for (int i = 0; i < 3; i++) begin
      pr1_q[i] <= $signed(side8_q.dx[i][XW-1:0]) * $signed(side8_q.l);
    end
  end

  always_comb begin
    sideb_in = side9_q;
    for (int i = 0; i < 3; i++) begin
      mag1 = (pr1_q[i] < 0) ? (2*XW)'(-pr1_q[i]) : (2*XW)'(pr1_q[i]);
      numb[i] = NW'(mag1);
      sideb_in.neg[i] = pr1_q[i][2*XW-1];
    end
    denb = side9_q.en1 ? DW'(side9_q.den1) : DW'(1);
  end

  // ---------------- divider B: clip below zero ----------------
  logic [2:0][NW-1:0] quo_b;
  bdpb_pkg::side_t    side_b;

  bdpb_div u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v9_q),
    .num_i   (numb),
    .den_i   (denb),
    .side_i  (sideb_in),
    .valid_o (vb),
    .quo_o   (quo_b),
    .side_o  (side_b)
  );

  // ---------------- S11: offsets after the low clip ----------------
  bdpb_pkg::side_t       side11_d, side11_q;
  logic signed [DXW-1:0] q1;

  always_comb begin
    side11_d = side_b;
    for (int i = 0; i < 3; i++) begin
      q1 = side_b.neg[i] ? -$signed(quo_b[i][DXW-1:0]) : $signed(quo_b[i][DXW-1:0]);
      if (side_b.en1) side11_d.dx[i] = q1;
    end
  end

  always_ff @(posedge clk_i) side11_q <= side11_d;

  // ---------------- S12: high clip numerators ----------------
  bdpb_pkg::side_t          side12_q, sidec_in;
  logic signed [DXW+XW-1:0] pr2_q [3];
  logic [2:0][NW-1:0]       numc;
  logic [DW-1:0]            denc;
  logic [DXW+XW-1:0]        mag2;

  always_ff @(posedge clk_i) begin
    side12_q <= side11_q;
    for (int i = 0; i < 3; i++) pr2_q[i] <= $signed(side11_q.dx[i]) * $signed(side11_q.oml);
  end

  always_comb begin
    sidec_in = side12_q;
    for (int i = 0; i < 3; i++) begin
      mag2 = (pr2_q[i] < 0) ? (DXW+XW)'(-pr2_q[i]) : (DXW+XW)'(pr2_q[i]);
      numc[i] = NW'(mag2);
      sidec_in.neg[i] = pr2_q[i][DXW+XW-1];
    end
    denc = side12_q.en2 ? DW'(side12_q.den2) : DW'(1);
  end

  // ---------------- divider C: clip above one ----------------
  logic [2:0][NW-1:0] quo_c;
  bdpb_pkg::side_t    side_c;

  bdpb_div u_div_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v12_q),
    .num_i   (numc),
    .den_i   (denc),
    .side_i  (sidec_in),
    .valid_o (vc),
    .quo_o   (quo_c),
    .side_o  (side_c)
  );

  // ---------------- S13: final colour, clamped to 0..ONE ----------------
  bdpb_pkg::side_t       side13_d, side13_q;
  logic signed [DXW-1:0] q2, dx2;
  logic signed [DXW:0]   xf;

  always_comb begin
    side13_d = side_c;
    for (int i = 0; i < 3; i++) begin
      q2  = side_c.neg[i] ? -$signed(quo_c[i][DXW-1:0]) : $signed(quo_c[i][DXW-1:0]);
      dx2 = side_c.en2 ? q2 : $signed(side_c.dx[i]);
      xf  = (DXW+1)'($signed(side_c.l)) + (DXW+1)'(dx2);
      if (xf < 0) begin
        side13_d.sx[i] = '0;
      end else if (xf > bdpb_pkg::ONE) begin
        side13_d.sx[i] = ONE_W;
      end else begin
        side13_d.sx[i] = xf[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) side13_q <= side13_d;

  // ---------------- S14: premultiply the colour-mode result ----------------
  bdpb_pkg::side_t side14_d, side14_q;
  logic [31:0]     pm;

  always_comb begin
    side14_d = side13_q;
    for (int i = 0; i < 3; i++) begin
      pm = side13_q.sx[i] * side13_q.ba;
      if (side13_q.mode == bdpb_pkg::MODE_COLOUR) side14_d.p[i] = 17'(pm >> FB);
    end
  end

  always_ff @(posedge clk_i) side14_q <= side14_d;

  // ---------------- S15: mix products ----------------
  bdpb_pkg::side_t  side15_q;
  logic [2:0][32:0] mp1_q;
  logic [2:0][31:0] mp2_q;
  logic [31:0]      ap_q;
  logic             paint;
  logic [15:0]      w1;

  assign paint = (side14_q.mode == bdpb_pkg::MODE_NORMAL) ||
                 (side14_q.mode == bdpb_pkg::MODE_LOCK);
  assign w1    = paint ? side14_q.t : side14_q.opa;

  always_ff @(posedge clk_i) begin
    side15_q <= side14_q;
    for (int i = 0; i < 3; i++) begin
      mp1_q[i] <= w1 * (paint ? {1'b0, brush_q[i]} : side14_q.p[i]);
      mp2_q[i] <= side14_q.inv * side14_q.c[i];
    end
    ap_q <= side14_q.inv * side14_q.ba;
  end

  // ---------------- S16: sum, shift, saturate ----------------
  bdpb_pkg::pix_out_t res_d, res_q;
  logic [18:0]        mix;
  logic [17:0]        at;
  logic [2:0][15:0]   oc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix   = 19'((34'(mp1_q[i]) + 34'(mp2_q[i])) >> FB);
      oc[i] = (mix > 19'(16'hFFFF)) ? 16'hFFFF : mix[15:0];
    end
    at = 18'(side15_q.t) + 18'(ap_q >> FB);
    res_d.out_red   = oc[0];
    res_d.out_green = oc[1];
    res_d.out_blue  = oc[2];
    if (side15_q.mode == bdpb_pkg::MODE_NORMAL) begin
      res_d.out_alpha = (at > 18'(16'hFFFF)) ? 16'hFFFF : at[15:0];
    end else begin
      res_d.out_alpha = side15_q.ba;
    end
  end

  always_ff @(posedge clk_i) res_q <= res_d;

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

[sv/bdpb_div.sv]
// Three-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
// Carries the pixel's side data along; depends on bdpb_pkg.
`default_nettype none

module bdpb_div (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic [2:0][bdpb_pkg::DIV_NUM_W-1:0]        num_i,
  input  logic [bdpb_pkg::DIV_DEN_W-1:0]             den_i,
  input  bdpb_pkg::side_t                            side_i,
  output logic                                       valid_o,
  output logic [2:0][bdpb_pkg::DIV_NUM_W-1:0]        quo_o,
  output bdpb_pkg::side_t                            side_o
);

  localparam int NW = bdpb_pkg::DIV_NUM_W;
  localparam int DW = bdpb_pkg::DIV_DEN_W;

  logic                     vld [0:NW];
  logic [2:0][NW-1:0]       nq  [0:NW];
  logic [DW-1:0]            dn  [0:NW];
  bdpb_pkg::side_t          sd  [0:NW];
  logic [2:0][DW-1:0]       rem [0:NW-1];

  assign vld[0] = valid_i;
  assign nq[0]  = num_i;
  assign dn[0]  = den_i;
  assign sd[0]  = side_i;
  assign rem[0] = '0;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [2:0][DW:0]   trial;
    logic [2:0]         ge;
    logic [2:0][DW-1:0] rem_d;
    logic [2:0][NW-1:0] nq_d;

    always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
        trial[ch] = {rem[k][ch], nq[k][ch][NW-1]};
        ge[ch]    = trial[ch] >= {1'b0, dn[k]};
        rem_d[ch] = ge[ch] ? DW'(trial[ch] - {1'b0, dn[k]}) : trial[ch][DW-1:0];
        nq_d[ch]  = {nq[k][ch][NW-2:0], ge[ch]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      nq[k+1] <= nq_d;
      dn[k+1] <= dn[k];
      sd[k+1] <= sd[k];
    end

    // the last stage keeps no remainder
    if (k < NW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem[k+1] <= rem_d;
      end
    end
  end

  assign valid_o = vld[NW];
  assign quo_o   = nq[NW];
  assign side_o  = sd[NW];

endmodule

`default_nettype wire
